@@ rtl/core/shtab_pkg.sv @@
// Shared types and constants for the spatial hash id table.
// No dependencies.
package shtab_pkg;

	localparam int KEY_W         = 16;
	localparam int ID_W          = 16;
	localparam int SUM_W         = 2 * KEY_W + 2;
	localparam int RES_CAP       = 16;
	localparam int HASH_ROWS_DEF = 1021;
	localparam int WAYS_DEF      = 4;
	localparam int IDS_DEF       = 16;

	typedef enum logic [1:0] {
		FN_INSERT,
		FN_REMOVE,
		FN_LOOKUP,
		FN_NONE
	} func_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_NO_BUCKET,
		ST_ROW_FULL,
		ST_IDS_FULL
	} status_t;

	typedef struct packed {
		func_t                    func;
		logic signed [KEY_W-1:0]  kx;
		logic signed [KEY_W-1:0]  ky;
		logic signed [KEY_W-1:0]  kz;
		logic        [ID_W-1:0]   id;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   found_id;
		logic              id_valid;
		logic              last;
	} res_t;

	typedef struct packed {
		logic clearing;
	} bk_stat_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_SUM,
		F_QUO,
		F_REM,
		F_FIX,
		F_PUSH
	} fst_t;

	typedef enum logic [4:0] {
		B_CLEAR,
		B_IDLE,
		B_BASE,
		B_PR_RD,
		B_PR_CK,
		B_SLOT,
		B_IDB,
		B_DISP,
		B_SC_RD,
		B_SC_CK,
		B_INS,
		B_UP_RD,
		B_UP_WR,
		B_DN_RD,
		B_DN_WR,
		B_LK_RD,
		B_LK_CK,
		B_RES
	} bst_t;

endpackage

@@ rtl/core/spatial_hash_id_table_core.sv @@
// Top level of the spatial hash id table: front, queues and back.
// Depends on shtab_pkg, shtab_fifo, shtab_front, shtab_back, shtab_ram.
// After reset the block sweeps all HASH_ROWS*WAYS_PER_ROW ways of the bucket
// table (4084 by default), one way per cycle, with full held high. Each word
// is then hashed in the front (square, add, reciprocal quotient, remainder,
// correction, hand-off) and, in the back, goes through the row probe and the
// result, plus a read and a check or a write per id slot scanned or shifted
// (a read, a check and a result per id emitted on a lookup); the two overlap
// through a two-entry queue, so the front can take a new word while the back
// works on the last, and the back sets the sustained rate. Results wait in a
// two-entry output queue.
module spatial_hash_id_table_core import shtab_pkg::*; #(
	parameter int HASH_ROWS      = HASH_ROWS_DEF,
	parameter int WAYS_PER_ROW   = WAYS_DEF,
	parameter int IDS_PER_BUCKET = IDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        func,
	input  logic [KEY_W-1:0]  key_x,
	input  logic [KEY_W-1:0]  key_y,
	input  logic [KEY_W-1:0]  key_z,
	input  logic [ID_W-1:0]   object_id,
	output logic              empty,
	input  logic              pop,
	output logic [1:0]        status,
	output logic [ID_W-1:0]   found_id,
	output logic              id_valid,
	output logic              last
);

	localparam int ROW_W = $clog2(HASH_ROWS);
	localparam int QW    = ROW_W + $bits(item_t);
	localparam int RW    = $bits(res_t);

	item_t           in_item;
	logic            f_ready, f_push, q_full, q_empty, q_pop, r_push, r_full;
	logic [QW-1:0]   f_data, q_data;
	res_t            b_res, out_res;
	logic [RW-1:0]   out_raw;
	bk_stat_t        bk_stat;

	assign in_item = '{func: func_t'(func), kx: key_x, ky: key_y, kz: key_z, id: object_id};
	assign full    = !f_ready || bk_stat.clearing;
	assign out_res = res_t'(out_raw);
	assign status   = out_res.status;
	assign found_id = out_res.found_id;
	assign id_valid = out_res.id_valid;
	assign last     = out_res.last;

	shtab_front #(.HASH_ROWS(HASH_ROWS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push && !bk_stat.clearing),
		.in_item  (in_item),
		.in_ready (f_ready),
		.q_push   (f_push),
		.q_data   (f_data),
		.q_full   (q_full)
	);

	shtab_fifo #(.W(QW), .DEPTH(2)) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_data),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_data),
		.empty  (q_empty)
	);

	shtab_back #(
		.HASH_ROWS      (HASH_ROWS),
		.WAYS_PER_ROW   (WAYS_PER_ROW),
		.IDS_PER_BUCKET (IDS_PER_BUCKET)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_data),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.r_push  (r_push),
		.r_data  (b_res),
		.r_full  (r_full),
		.stat    (bk_stat)
	);

	shtab_fifo #(.W(RW), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (r_push),
		.wdata  (b_res),
		.full   (r_full),
		.pop    (pop),
		.rdata  (out_raw),
		.empty  (empty)
	);

`ifndef SYNTHESIS
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.clearing |-> full)
		else $error("word accepted during table sweep");
	a_no_id_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !id_valid) |-> last)
		else $error("non-id result without last");
	a_status_id: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> !id_valid)
		else $error("error status carries an id");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.clearing |-> empty)
		else $error("result during table sweep");
`endif

endmodule

@@ rtl/core/shtab_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module shtab_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16,
	localparam int A_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic           clk,
	input  logic           we,
	input  logic [A_W-1:0] waddr,
	input  logic [W-1:0]   wdata,
	input  logic [A_W-1:0] raddr,
	output logic [W-1:0]   rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/shtab_fifo.sv @@
// Small register queue used between front and back and at the result side.
// No dependencies.
module shtab_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2,
	localparam int P_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int C_W  = $clog2(DEPTH + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	logic [W-1:0]   mem_q [DEPTH];
	logic [P_W-1:0] wp_q, rp_q;
	logic [C_W-1:0] cnt_q;
	logic           do_push, do_pop;

	assign full    = (cnt_q == C_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == P_W'(DEPTH - 1)) ? '0 : P_W'(wp_q + 1'b1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == P_W'(DEPTH - 1)) ? '0 : P_W'(rp_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= C_W'(cnt_q + 1'b1);
			end else if (do_pop && !do_push) begin
				cnt_q <= C_W'(cnt_q - 1'b1);
			end
		end
	end

endmodule

@@ rtl/core/shtab_front.sv @@
// Front part: takes a word, squares the key, reduces the sum mod the row count.
// Depends on shtab_pkg.
module shtab_front import shtab_pkg::*; #(
	parameter int HASH_ROWS = HASH_ROWS_DEF,
	localparam int ROW_W    = $clog2(HASH_ROWS),
	localparam int QW       = ROW_W + $bits(item_t)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  item_t         in_item,
	output logic          in_ready,
	output logic          q_push,
	output logic [QW-1:0] q_data,
	input  logic          q_full
);

	// quotient estimate (sum >> (ROW_W-1)) * MU >> QB is short by at most two
	localparam int QB = SUM_W - ROW_W + 1;
	localparam longint unsigned MU_L = (64'd1 << SUM_W) / 64'(HASH_ROWS);
	localparam logic [QB-1:0] MU = QB'(MU_L);

	fst_t                      st_q, st_nx;
	item_t                     it_q;
	logic [2*KEY_W-1:0]        sqx_q, sqy_q, sqz_q;
	logic [SUM_W-1:0]          sum_q;
	logic [QB-1:0]             quo_q;
	logic [ROW_W+1:0]          rem_q;
	logic [ROW_W-1:0]          row_q;
	logic signed [2*KEY_W-1:0] px, py, pz;
	logic [2*QB-1:0]           prod;
	logic [SUM_W-1:0]          qd, diff;
	logic [ROW_W+1:0]          f1, f2;

	always_comb begin
		px   = it_q.kx * it_q.kx;
		py   = it_q.ky * it_q.ky;
		pz   = it_q.kz * it_q.kz;
		prod = sum_q[SUM_W-1:ROW_W-1] * MU;
		qd   = SUM_W'(quo_q) * SUM_W'(HASH_ROWS);
		diff = sum_q - qd;
		f1   = rem_q;
		if (f1 >= (ROW_W+2)'(HASH_ROWS)) begin
			f1 = f1 - (ROW_W+2)'(HASH_ROWS);
		end
		f2 = f1;
		if (f2 >= (ROW_W+2)'(HASH_ROWS)) begin
			f2 = f2 - (ROW_W+2)'(HASH_ROWS);
		end
	end

	assign in_ready = (st_q == F_IDLE);
	assign q_push   = (st_q == F_PUSH) && !q_full;
	assign q_data   = {row_q, it_q};

	always_comb begin
		st_nx = st_q;
		case (st_q)
			F_IDLE: if (in_valid) st_nx = F_MUL;
			F_MUL:  st_nx = F_SUM;
			F_SUM:  st_nx = F_QUO;
			F_QUO:  st_nx = F_REM;
			F_REM:  st_nx = F_FIX;
			F_FIX:  st_nx = F_PUSH;
			F_PUSH: if (!q_full) st_nx = F_IDLE;
			default: st_nx = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			st_q <= st_nx;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			F_IDLE: begin
				if (in_valid) it_q <= in_item;
			end
			F_MUL: begin
				sqx_q <= $unsigned(px);
				sqy_q <= $unsigned(py);
				sqz_q <= $unsigned(pz);
			end
			F_SUM: sum_q <= SUM_W'(sqx_q) + SUM_W'(sqy_q) + SUM_W'(sqz_q);
			F_QUO: quo_q <= prod[2*QB-1:QB];
			F_REM: rem_q <= diff[ROW_W+1:0];
			F_FIX: row_q <= f2[ROW_W-1:0];
			default: ;
		endcase
	end

endmodule

@@ rtl/core/shtab_back.sv @@
// Back part: probes the row's ways and walks or shifts the bucket's id slots.
// Depends on shtab_pkg, shtab_ram.
module shtab_back import shtab_pkg::*; #(
	parameter int HASH_ROWS    = HASH_ROWS_DEF,
	parameter int WAYS_PER_ROW = WAYS_DEF,
	parameter int IDS_PER_BUCKET = IDS_DEF,
	localparam int ROW_W       = $clog2(HASH_ROWS),
	localparam int QW          = ROW_W + $bits(item_t)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [QW-1:0] q_data,
	input  logic          q_empty,
	output logic          q_pop,
	output logic          r_push,
	output res_t          r_data,
	input  logic          r_full,
	output bk_stat_t      stat
);

	localparam int SLOTS  = HASH_ROWS * WAYS_PER_ROW;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int WAY_W  = (WAYS_PER_ROW > 1) ? $clog2(WAYS_PER_ROW) : 1;
	localparam int CNT_W  = $clog2(IDS_PER_BUCKET + 1);
	localparam int IDA_W  = $clog2(SLOTS * IDS_PER_BUCKET);
	localparam int META_W = 3 * KEY_W + CNT_W;
	localparam int CAP    = (IDS_PER_BUCKET < RES_CAP) ? IDS_PER_BUCKET : RES_CAP;

	bst_t               st_q, st_nx;
	item_t              it_q;
	logic [ROW_W-1:0]   row_q;
	logic [SLOT_W-1:0]  base_q, slot_q, clr_q;
	logic [WAY_W-1:0]   way_q, hitw_q, freew_q;
	logic               hit_q, free_q, more_q;
	logic [CNT_W-1:0]   n_q, i_q, j_q;
	logic [IDA_W-1:0]   idb_q;
	res_t               res_q;

	logic               m_we, d_we;
	logic [SLOT_W-1:0]  m_waddr, m_raddr;
	logic [META_W-1:0]  m_wdata, m_rdata;
	logic [IDA_W-1:0]   d_waddr, d_raddr;
	logic [ID_W-1:0]    d_wdata, d_rdata;
	logic [CNT_W-1:0]   m_cnt;
	logic [3*KEY_W-1:0] key;
	logic               key_eq, lk_last;

	assign key     = {it_q.kx, it_q.ky, it_q.kz};
	assign m_cnt   = m_rdata[CNT_W-1:0];
	assign key_eq  = (m_rdata[META_W-1:CNT_W] == key);
	assign lk_last = (CNT_W'(i_q + 1'b1) == n_q) || (CNT_W'(i_q + 1'b1) == CNT_W'(CAP));

	shtab_ram #(.W(META_W), .DEPTH(SLOTS)) u_meta (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	shtab_ram #(.W(ID_W), .DEPTH(SLOTS * IDS_PER_BUCKET)) u_ids (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	assign q_pop  = (st_q == B_IDLE) && !q_empty;
	assign r_push = (st_q == B_RES) && !r_full;
	assign r_data = res_q;
	assign stat   = '{clearing: (st_q == B_CLEAR)};

	always_comb begin
		m_we    = 1'b0;
		m_waddr = slot_q;
		m_wdata = {key, CNT_W'(1)};
		m_raddr = SLOT_W'(base_q + SLOT_W'(way_q));
		d_we    = 1'b0;
		d_waddr = IDA_W'(idb_q + IDA_W'(i_q));
		d_wdata = it_q.id;
		d_raddr = IDA_W'(idb_q + IDA_W'(i_q));
		case (st_q)
			B_CLEAR: begin
				m_we    = 1'b1;
				m_waddr = clr_q;
				m_wdata = '0;
			end
			B_DISP: begin
				if (it_q.func == FN_INSERT && !hit_q && free_q) begin
					m_we = 1'b1;
					d_we = 1'b1;
				end
			end
			B_UP_RD: begin
				if (j_q == i_q) begin
					d_we    = 1'b1;
					m_we    = 1'b1;
					m_wdata = {key, CNT_W'(n_q + 1'b1)};
				end else begin
					d_raddr = IDA_W'(idb_q + IDA_W'(j_q) - 1'b1);
				end
			end
			B_UP_WR: begin
				d_we    = 1'b1;
				d_waddr = IDA_W'(idb_q + IDA_W'(j_q));
				d_wdata = d_rdata;
			end
			B_DN_RD: begin
				if (CNT_W'(i_q + 1'b1) >= n_q) begin
					m_we    = 1'b1;
					m_wdata = {key, CNT_W'(n_q - 1'b1)};
				end else begin
					d_raddr = IDA_W'(idb_q + IDA_W'(i_q) + 1'b1);
				end
			end
			B_DN_WR: begin
				d_we    = 1'b1;
				d_wdata = d_rdata;
			end
			default: ;
		endcase
	end

	always_comb begin
		st_nx = st_q;
		case (st_q)
			B_CLEAR: if (clr_q == SLOT_W'(SLOTS - 1)) st_nx = B_IDLE;
			B_IDLE:  if (!q_empty) st_nx = B_BASE;
			B_BASE:  st_nx = B_PR_RD;
			B_PR_RD: st_nx = B_PR_CK;
			B_PR_CK: st_nx = (way_q == WAY_W'(WAYS_PER_ROW - 1)) ? B_SLOT : B_PR_RD;
			B_SLOT:  st_nx = B_IDB;
			B_IDB:   st_nx = B_DISP;
			B_DISP: begin
				if (hit_q && it_q.func != FN_NONE) begin
					st_nx = (it_q.func == FN_LOOKUP) ? B_LK_RD : B_SC_RD;
				end else begin
					st_nx = B_RES;
				end
			end
			B_SC_RD: begin
				if (i_q == n_q) st_nx = (it_q.func == FN_INSERT) ? B_INS : B_RES;
				else st_nx = B_SC_CK;
			end
			B_SC_CK: begin
				if (d_rdata == it_q.id) begin
					st_nx = (it_q.func == FN_INSERT) ? B_RES : B_DN_RD;
				end else if (it_q.func == FN_INSERT && d_rdata > it_q.id) begin
					st_nx = B_INS;
				end else begin
					st_nx = B_SC_RD;
				end
			end
			B_INS:   st_nx = (n_q == CNT_W'(IDS_PER_BUCKET)) ? B_RES : B_UP_RD;
			B_UP_RD: st_nx = (j_q == i_q) ? B_RES : B_UP_WR;
			B_UP_WR: st_nx = B_UP_RD;
			B_DN_RD: st_nx = (CNT_W'(i_q + 1'b1) >= n_q) ? B_RES : B_DN_WR;
			B_DN_WR: st_nx = B_DN_RD;
			B_LK_RD: st_nx = B_LK_CK;
			B_LK_CK: st_nx = B_RES;
			B_RES:   if (!r_full) st_nx = more_q ? B_LK_RD : B_IDLE;
			default: st_nx = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= B_CLEAR;
			clr_q <= '0;
		end else begin
			st_q <= st_nx;
			if (st_q == B_CLEAR) clr_q <= SLOT_W'(clr_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				if (!q_empty) begin
					it_q  <= item_t'(q_data[$bits(item_t)-1:0]);
					row_q <= q_data[QW-1:$bits(item_t)];
				end
			end
			B_BASE: begin
				base_q <= SLOT_W'(SLOT_W'(row_q) * SLOT_W'(WAYS_PER_ROW));
				way_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end
			B_PR_CK: begin
				if (m_cnt != '0 && key_eq && !hit_q) begin
					hit_q  <= 1'b1;
					hitw_q <= way_q;
					n_q    <= m_cnt;
				end
				if (m_cnt == '0 && !free_q) begin
					free_q  <= 1'b1;
					freew_q <= way_q;
				end
				way_q <= WAY_W'(way_q + 1'b1);
			end
			B_SLOT: slot_q <= SLOT_W'(base_q + SLOT_W'(hit_q ? hitw_q : freew_q));
			B_IDB: begin
				idb_q <= IDA_W'(IDA_W'(slot_q) * IDA_W'(IDS_PER_BUCKET));
				i_q   <= '0;
			end
			B_DISP: begin
				more_q <= 1'b0;
				res_q  <= '{status: ST_OK, found_id: '0, id_valid: 1'b0, last: 1'b1};
				case (it_q.func)
					FN_INSERT: if (!hit_q && !free_q) res_q.status <= ST_ROW_FULL;
					FN_REMOVE: if (!hit_q) res_q.status <= ST_NO_BUCKET;
					FN_LOOKUP: if (!hit_q) res_q.status <= ST_NO_BUCKET;
					default: ;
				endcase
			end
			B_SC_CK: begin
				if (d_rdata != it_q.id && !(it_q.func == FN_INSERT && d_rdata > it_q.id)) begin
					i_q <= CNT_W'(i_q + 1'b1);
				end
			end
			B_INS: begin
				j_q <= n_q;
				if (n_q == CNT_W'(IDS_PER_BUCKET)) res_q.status <= ST_IDS_FULL;
			end
			B_UP_WR: j_q <= CNT_W'(j_q - 1'b1);
			B_DN_WR: i_q <= CNT_W'(i_q + 1'b1);
			B_LK_CK: begin
				res_q  <= '{status: ST_OK, found_id: d_rdata, id_valid: 1'b1, last: lk_last};
				more_q <= !lk_last;
			end
			B_RES: if (!r_full && more_q) i_q <= CNT_W'(i_q + 1'b1);
			default: ;
		endcase
	end

endmodule
